// ===== hdl/secure_element_command_framer_assert.svh =====
// Assertion macros shared by the command framer RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef SECURE_ELEMENT_COMMAND_FRAMER_ASSERT_SVH
`define SECURE_ELEMENT_COMMAND_FRAMER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define SECF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define SECF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/secf_pkg.sv =====
// Package for the secure element command framer.
// Command record, back-end state codes, CRC-16 helpers. No dependencies.
package secf_pkg;

  localparam logic [7:0]  WordAddr  = 8'h03;
  localparam logic [7:0]  CountBase = 8'd7;
  localparam logic [15:0] CrcPoly   = 16'hA001;
  localparam logic [2:0]  LastHdrStep = 3'd5;

  typedef enum logic {
    KIND_HDR  = 1'b0,
    KIND_DATA = 1'b1
  } kind_e;

  // back-end sequencer, one-hot
  typedef enum logic [2:0] {
    ST_BYTE   = 3'b001,
    ST_CRC_LO = 3'b010,
    ST_CRC_HI = 3'b100
  } back_state_e;

  // one classified command in the queue
  typedef struct packed {
    logic        is_hdr;
    logic        last;       // checksum follows this command
    logic [7:0]  cnt;
    logic [7:0]  opcode;
    logic [7:0]  param1;
    logic [15:0] param2;
    logic [7:0]  data_byte;
  } cmd_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

  // reflected CRC-16, one byte LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] r_in, input logic [7:0] b);
    logic [15:0] r;
    r = r_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CrcPoly;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic logic [15:0] rev16(input logic [15:0] v);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) begin
      r[15 - i] = v[i];
    end
    return r;
  endfunction

endpackage

// ===== hdl/secf_front.sv =====
// Front end of the command framer: accepts input transfers, tracks packet
// state and pushes classified commands. Depends on secf_pkg.
module secf_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             kind_i,
  input  logic [7:0]       opcode_i,
  input  logic [7:0]       param1_i,
  input  logic [15:0]      param2_i,
  input  logic [7:0]       data_len_i,
  input  logic [7:0]       data_byte_i,
  input  secf_pkg::q_stat_t stat_i,
  output logic             push_o,
  output secf_pkg::cmd_t   cmd_o
);
  import secf_pkg::*;

  logic       in_packet_q, in_packet_d;
  logic [7:0] bytes_left_q, bytes_left_d;
  logic       accept;

  assign in_ready_o = !stat_i.full;
  assign accept     = in_valid_i && !stat_i.full;

  // classify; wrong-kind items are taken and dropped
  always_comb begin
    in_packet_d     = in_packet_q;
    bytes_left_d    = bytes_left_q;
    push_o          = 1'b0;
    cmd_o.is_hdr    = (kind_i == KIND_HDR);
    cmd_o.last      = 1'b0;
    cmd_o.cnt       = data_len_i + CountBase;
    cmd_o.opcode    = opcode_i;
    cmd_o.param1    = param1_i;
    cmd_o.param2    = param2_i;
    cmd_o.data_byte = data_byte_i;
    if (accept) begin
      if (kind_i == KIND_HDR) begin
        if (!in_packet_q) begin
          push_o     = 1'b1;
          cmd_o.last = (data_len_i == 8'd0);
          if (data_len_i != 8'd0) begin
            in_packet_d  = 1'b1;
            bytes_left_d = data_len_i;
          end
        end
      end else if (in_packet_q) begin
        push_o       = 1'b1;
        cmd_o.last   = (bytes_left_q == 8'd1);
        bytes_left_d = bytes_left_q - 8'd1;
        if (bytes_left_q == 8'd1) begin
          in_packet_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_packet_q  <= 1'b0;
      bytes_left_q <= 8'd0;
    end else begin
      in_packet_q  <= in_packet_d;
      bytes_left_q <= bytes_left_d;
    end
  end

`include "secure_element_command_framer_assert.svh"
  `SECF_ASSERT_NEXT(a_last_data_closes, push_o && !cmd_o.is_hdr && cmd_o.last, !in_packet_q, "last data byte left packet open")
  `SECF_ASSERT_NEXT(a_hdr_opens, push_o && cmd_o.is_hdr && !cmd_o.last, in_packet_q && bytes_left_q != 8'd0, "header with payload did not open packet")

endmodule

// ===== hdl/secf_queue.sv =====
// Short command queue between front and back end.
// Register storage, single read pointer. Depends on secf_pkg.
module secf_queue #(
  parameter int QDepth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  secf_pkg::cmd_t    cmd_i,
  input  logic              pop_i,
  output secf_pkg::cmd_t    head_o,
  output secf_pkg::q_stat_t stat_o
);
  import secf_pkg::*;

  localparam int PtrW = $clog2(QDepth);
  localparam int CntW = $clog2(QDepth + 1);

  cmd_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign stat_o.full      = (count_q == CntW'(QDepth));
  assign stat_o.not_empty = (count_q != '0);
  assign do_push          = push_i && !stat_o.full;
  assign do_pop           = pop_i && stat_o.not_empty;
  assign head_o           = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!do_push && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

`include "secure_element_command_framer_assert.svh"
  `SECF_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(QDepth), "queue fill count overran depth")
  `SECF_ASSERT_NOW(a_no_push_full, push_i, !stat_o.full, "push into a full queue")

endmodule

// ===== hdl/secf_back.sv =====
// Back end of the command framer: serialises each queued command to bytes,
// runs the CRC and drives the output register. Depends on secf_pkg.
module secf_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  secf_pkg::cmd_t    head_i,
  input  secf_pkg::q_stat_t stat_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              frame_end_o
);
  import secf_pkg::*;

  back_state_e state_q, state_d;
  logic [2:0]  step_q, step_d;
  logic [15:0] crc_q, crc_d, crc_rev;
  logic        out_valid_q;
  logic [7:0]  out_byte_q, byte_d;
  logic        frame_end_q, end_d;
  logic        slot_free, fire;

  assign slot_free = !out_valid_q || out_ready_i;
  assign fire      = stat_i.not_empty && slot_free;
  assign crc_rev   = rev16(crc_q);

  // one output byte per fire
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    crc_d   = crc_q;
    byte_d  = head_i.data_byte;
    end_d   = 1'b0;
    pop_o   = 1'b0;
    if (fire) begin
      unique case (state_q)
        ST_BYTE: begin
          if (head_i.is_hdr) begin
            unique case (step_q)
              3'd0:    byte_d = WordAddr;
              3'd1:    byte_d = head_i.cnt;
              3'd2:    byte_d = head_i.opcode;
              3'd3:    byte_d = head_i.param1;
              3'd4:    byte_d = head_i.param2[7:0];
              3'd5:    byte_d = head_i.param2[15:8];
              default: byte_d = WordAddr;
            endcase
            // word address is outside the checksum and restarts it
            crc_d = (step_q == 3'd0) ? 16'h0000 : crc_byte(crc_q, byte_d);
            if (step_q == LastHdrStep) begin
              step_d = 3'd0;
              if (head_i.last) begin
                state_d = ST_CRC_LO;
              end else begin
                pop_o = 1'b1;
              end
            end else begin
              step_d = step_q + 3'd1;
            end
          end else begin
            crc_d = crc_byte(crc_q, head_i.data_byte);
            if (head_i.last) begin
              state_d = ST_CRC_LO;
            end else begin
              pop_o = 1'b1;
            end
          end
        end
        ST_CRC_LO: begin
          byte_d  = crc_rev[7:0];
          state_d = ST_CRC_HI;
        end
        ST_CRC_HI: begin
          byte_d  = crc_rev[15:8];
          end_d   = 1'b1;
          pop_o   = 1'b1;
          state_d = ST_BYTE;
        end
        default: state_d = ST_BYTE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_BYTE;
      step_q      <= 3'd0;
      crc_q       <= 16'h0000;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      crc_q   <= crc_d;
      if (slot_free) begin
        out_valid_q <= fire;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_byte_q  <= byte_d;
      frame_end_q <= end_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign frame_end_o = frame_end_q;

`include "secure_element_command_framer_assert.svh"
  `SECF_ASSERT_NOW(a_crc_has_head, state_q != ST_BYTE, stat_i.not_empty, "checksum phase without a queued command")
  `SECF_ASSERT_NOW(a_step_range, state_q == ST_BYTE, step_q <= LastHdrStep, "header step out of range")

endmodule

// ===== hdl/secure_element_command_framer.sv =====
// Top level of the secure element command framer.
// Instantiates secf_front, secf_queue and secf_back; uses secf_pkg.
//
//   channel  | direction | fields
//   ---------+-----------+-----------------------------------------------
//   in       | input     | kind, opcode, param1, param2, data_len, data_byte
//   out      | output    | out_byte, frame_end
//
// Output runs at one byte per cycle while out_ready_i is high and a command is queued;
// a data item gives one byte, three when it is the last of its packet, a header
// gives six bytes of the byte serialiser, eight when the length is zero.
// The front accepts an item every cycle while the QDepth-entry command
// queue has room; ignored items are taken and dropped at once.
// Reset clears packet state, the queue and the output valid.
// A stalled output holds its byte; the queue then fills and drops in_ready_o.
module secure_element_command_framer #(
  parameter int QDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  opcode_i,
  input  logic [7:0]  param1_i,
  input  logic [15:0] param2_i,
  input  logic [7:0]  data_len_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        frame_end_o
);
  import secf_pkg::*;

  cmd_t    push_cmd, head_cmd;
  q_stat_t q_stat;
  logic    push, pop;

  secf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .opcode_i    (opcode_i),
    .param1_i    (param1_i),
    .param2_i    (param2_i),
    .data_len_i  (data_len_i),
    .data_byte_i (data_byte_i),
    .stat_i      (q_stat),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  secf_queue #(
    .QDepth (QDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .head_o (head_cmd),
    .stat_o (q_stat)
  );

  secf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .stat_i      (q_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .frame_end_o (frame_end_o)
  );

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for secure_element_command_framer.
// Directed table then random command packets, checked byte by byte against an
// in-bench predictor of the framing and CRC-16. Depends on secf_pkg and the RTL.
module testbench;
  import secf_pkg::*;

  localparam logic [7:0]  WORD_ADDR_BYTE = 8'h03;
  localparam logic [7:0]  COUNT_OFFSET   = 8'd7;
  localparam logic [15:0] POLY_REFL      = 16'hA001;
  localparam int          RANDOM_ITEMS   = 56;
  localparam int          QUIET_FROM     = 44;
  localparam int          CYCLE_LIMIT    = 400000;
  localparam int          DRAIN_CYCLES   = 20;

  // one byte of the framed packet
  typedef struct packed {
    logic [7:0] data;
    logic       frame_end;
  } frame_byte_t;

  // one row of the directed table; n_out < 0 leaves the count to the predictor
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  opcode;
    logic [7:0]  param1;
    logic [15:0] param2;
    logic [7:0]  data_len;
    logic [7:0]  data_byte;
    int          reps;
    int          n_out;
  } stim_row_t;

  localparam int NUM_ROWS = 17;
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // data straight after reset is dropped
    '{KIND_DATA, 8'h00, 8'h00, 16'h0000, 8'd0,   8'h5A, 1,   0},
    // empty payload, all zeros then all ones
    '{KIND_HDR,  8'h00, 8'h00, 16'h0000, 8'd0,   8'h00, 1,   8},
    '{KIND_HDR,  8'hFF, 8'hFF, 16'hFFFF, 8'd0,   8'hFF, 1,   8},
    // one data byte; a second header inside the packet is dropped
    '{KIND_HDR,  8'h41, 8'h02, 16'h1234, 8'd1,   8'hFF, 1,   6},
    '{KIND_HDR,  8'h99, 8'h99, 16'h9999, 8'd3,   8'h00, 1,   0},
    '{KIND_DATA, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF,  8'hFF, 1,   3},
    // data between packets is dropped
    '{KIND_DATA, 8'h00, 8'h00, 16'h0000, 8'd0,   8'h11, 1,   0},
    '{KIND_HDR,  8'h80, 8'h01, 16'h8001, 8'd2,   8'h00, 1,   6},
    '{KIND_DATA, 8'h00, 8'h00, 16'h0000, 8'd0,   8'h00, 1,   1},
    '{KIND_DATA, 8'h00, 8'h00, 16'h0000, 8'd0,   8'hA5, 1,   3},
    // count wraps to zero, payload still 249 bytes
    '{KIND_HDR,  8'h2A, 8'h55, 16'hAAAA, 8'd249, 8'h00, 1,   6},
    '{KIND_HDR,  8'h00, 8'h00, 16'h0000, 8'd0,   8'h00, 1,   0},
    '{KIND_DATA, 8'h00, 8'h00, 16'h0000, 8'd0,   8'h80, 248, -1},
    '{KIND_DATA, 8'h00, 8'h00, 16'h0000, 8'd0,   8'hC3, 1,   3},
    '{KIND_HDR,  8'h5E, 8'hA7, 16'hFF00, 8'd1,   8'h00, 1,   6},
    '{KIND_DATA, 8'h00, 8'h00, 16'h0000, 8'd0,   8'h7E, 1,   3},
    '{KIND_DATA, 8'h00, 8'h00, 16'h0000, 8'd0,   8'h01, 1,   0}
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic        kind_i      = 1'b0;
  logic [7:0]  opcode_i    = '0;
  logic [7:0]  param1_i    = '0;
  logic [15:0] param2_i    = '0;
  logic [7:0]  data_len_i  = '0;
  logic [7:0]  data_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        frame_end_o;

  // predictor state
  logic [15:0] crc_run   = '0;
  logic [7:0]  bytes_due = '0;
  logic        in_frame  = 1'b0;

  frame_byte_t pending_frame_bytes [$];
  int          errors      = 0;
  int          cycles      = 0;
  int          stall_left  = 0;
  logic        quiet_tail  = 1'b0;

  secure_element_command_framer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .opcode_i    (opcode_i),
    .param1_i    (param1_i),
    .param2_i    (param2_i),
    .data_len_i  (data_len_i),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .frame_end_o (frame_end_o)
  );

  always #5 clk_i = ~clk_i;

  // cycle count and watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    errors++;
    $display("cycle %0d: %s: got %h, expected %h", cycles, what, got, want);
  endtask

  // reflected CRC-16, one byte taken LSB first
  function automatic logic [15:0] crc16_fold(logic [15:0] acc, logic [7:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb  = acc[0] ^ b[i];
      acc = acc >> 1;
      if (fb) begin
        acc = acc ^ POLY_REFL;
      end
    end
    return acc;
  endfunction

  function automatic logic [15:0] bit_reverse16(logic [15:0] v);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) begin
      r[i] = v[15 - i];
    end
    return r;
  endfunction

  // append the checksum bytes and go back to waiting for a header
  function automatic int close_frame();
    logic [15:0] c;
    c = bit_reverse16(crc_run);
    pending_frame_bytes.push_back('{data: c[7:0], frame_end: 1'b0});
    pending_frame_bytes.push_back('{data: c[15:8], frame_end: 1'b1});
    in_frame  = 1'b0;
    bytes_due = '0;
    crc_run   = '0;
    return 2;
  endfunction

  // bytes produced by one accepted item; returns how many
  function automatic int predict_frame_bytes(kind_e k, logic [7:0] op, logic [7:0] p1,
                                             logic [15:0] p2, logic [7:0] len,
                                             logic [7:0] db);
    logic [7:0] hdr [5];
    logic [7:0] cnt;
    int         produced;
    produced = 0;
    if (k == KIND_HDR) begin
      if (in_frame) begin
        return 0;
      end
      cnt    = len + COUNT_OFFSET;
      hdr[0] = cnt;
      hdr[1] = op;
      hdr[2] = p1;
      hdr[3] = p2[7:0];
      hdr[4] = p2[15:8];
      pending_frame_bytes.push_back('{data: WORD_ADDR_BYTE, frame_end: 1'b0});
      produced = 1;
      crc_run  = '0;
      for (int i = 0; i < 5; i++) begin
        pending_frame_bytes.push_back('{data: hdr[i], frame_end: 1'b0});
        crc_run = crc16_fold(crc_run, hdr[i]);
        produced++;
      end
      if (len == 8'd0) begin
        produced += close_frame();
      end else begin
        in_frame  = 1'b1;
        bytes_due = len;
      end
    end else if (in_frame) begin
      pending_frame_bytes.push_back('{data: db, frame_end: 1'b0});
      crc_run   = crc16_fold(crc_run, db);
      bytes_due = bytes_due - 8'd1;
      produced  = 1;
      if (bytes_due == 8'd0) begin
        produced += close_frame();
      end
    end
    return produced;
  endfunction

  // one input transfer, with an optional gap first; called at a rising edge
  task automatic send_item(input kind_e k, input logic [7:0] op, input logic [7:0] p1,
                           input logic [15:0] p2, input logic [7:0] len,
                           input logic [7:0] db, output int n_out);
    if (!quiet_tail && ((cycles / 500) % 4 != 3) && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= k;
    opcode_i    <= op;
    param1_i    <= p1;
    param2_i    <= p2;
    data_len_i  <= len;
    data_byte_i <= db;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_out = predict_frame_bytes(k, op, p1, p2, len, db);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_frame_bytes.size() != 0) @(posedge clk_i);
  endtask

  // output side: bursts of back-pressure, none in some stretches and at the end
  always @(posedge clk_i) begin
    if (quiet_tail || (cycles / 700) % 3 == 2) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left  = stall_left - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left  = $urandom_range(1, 10) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // compare each output transfer with the oldest expected byte
  always @(posedge clk_i) begin
    frame_byte_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_frame_bytes.size() == 0) begin
        report_mismatch("unexpected byte", {8'h00, out_byte_o}, 16'h0000);
      end else begin
        want = pending_frame_bytes.pop_front();
        if (out_byte_o !== want.data) begin
          report_mismatch("out_byte", {8'h00, out_byte_o}, {8'h00, want.data});
        end
        if (frame_end_o !== want.frame_end) begin
          report_mismatch("frame_end", {15'h0, frame_end_o}, {15'h0, want.frame_end});
        end
      end
    end
  end

  initial begin
    stim_row_t   row;
    int          n_out;
    int          rand_done;
    int          len;
    logic [7:0]  rb;
    rand_done = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int r = 0; r < NUM_ROWS; r++) begin
      row = DIRECTED_ROWS[r];
      for (int k = 0; k < row.reps; k++) begin
        send_item(row.kind, row.opcode, row.param1, row.param2, row.data_len,
                  row.data_byte + 8'(k), n_out);
        if (row.n_out >= 0 && n_out != row.n_out) begin
          report_mismatch("byte count of directed row", 16'(n_out), 16'(row.n_out));
        end
      end
    end

    // hold the input until the block has emptied
    wait_drained();
    @(posedge clk_i);

    // random packets with stray items mixed in
    while (rand_done < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(KIND_DATA, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
                  8'($urandom), n_out);
      end
      rb = 8'($urandom_range(0, 99));
      if (rb < 8'd6) begin
        len = $urandom_range(9, 24);
      end else if (rb < 8'd20) begin
        len = 0;
      end else begin
        len = $urandom_range(1, 8);
      end
      send_item(KIND_HDR, 8'($urandom), 8'($urandom), 16'($urandom), 8'(len),
                8'($urandom), n_out);
      rand_done++;
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_item(KIND_HDR, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
                    8'($urandom), n_out);
        end
        send_item(KIND_DATA, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
                  8'($urandom), n_out);
        rand_done++;
      end
      if (rand_done >= QUIET_FROM) begin
        quiet_tail = 1'b1;
      end else if ($urandom_range(0, 14) == 0) begin
        wait_drained();
        @(posedge clk_i);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
